[design/pcs_pkg.sv]
// Package for the streaming pattern censor: shared constants, codes and types.
// No dependencies; pcs_cell, pcs_seq and the top level import it.
`default_nettype none

package pcs_pkg;

   localparam int PATTERN_BYTES       = 16;   // bytes held by the two pattern registers
   localparam int MAX_PATTERN_DEFAULT = 16;
   localparam int CSR_DATA_W          = 64;
   localparam int CSR_INDEX_W         = 2;
   localparam int LEN_FIELD_W         = 5;

   localparam logic [7:0] STAR_CHAR    = 8'h2A;
   localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LEN  = 2'd0,
      CSR_PATTERN_LOW  = 2'd1,
      CSR_PATTERN_HIGH = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } pcs_state_type;

   // Control broadcast along the cell chain.
   typedef struct packed {
      logic       shift;        // every cell takes its right neighbor's byte
      logic       append;       // the selected cell loads append_byte
      logic [7:0] append_byte;
   } cell_ctrl_type;

endpackage

`default_nettype wire

[design/pcs_req_if.sv]
// Input channel of the pattern censor: valid/ready plus one input item.
// Depends on nothing.
`default_nettype none

interface pcs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       stream_end;

   modport source (output valid, output in_byte, output stream_end, input ready);
   modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

`default_nettype wire

[design/pcs_rsp_if.sv]
// Result channel of the pattern censor: valid/ready plus one result item.
// Depends on nothing.
`default_nettype none

interface pcs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;

   modport source (output valid, output out_byte, output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

[design/pcs_cell.sv]
// One window cell of the censor chain: holds a pending byte and checks it
// against its pattern byte. Depends on pcs_pkg.
`default_nettype none

module pcs_cell (
   input  wire                    clock,
   input  wire pcs_pkg::cell_ctrl_type ctrl,
   input  wire                    sel,        // this cell is the append slot
   input  wire                    care,       // position lies inside the pattern
   input  wire [7:0]              pat_byte,
   input  wire [7:0]              next_byte,  // right neighbor's byte
   output logic [7:0]             win_byte,
   output logic                   ok
);
   import pcs_pkg::*;

   logic [7:0] win_ff;
   logic [7:0] win_in;

   always_comb begin
      win_in = win_ff;
      if (ctrl.shift) begin
         win_in = next_byte;
      end else if (ctrl.append && sel) begin
         win_in = ctrl.append_byte;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   assign win_byte = win_ff;
   assign ok       = !care || (win_ff == pat_byte);

endmodule

`default_nettype wire

[design/pcs_seq.sv]
// Sequencer of the censor: takes items, steps the window chain, decides
// star/pass/flush and drives the result register. Depends on pcs_pkg and
// the two channel interfaces.
`default_nettype none

module pcs_seq #(
   parameter int MAX_PATTERN = pcs_pkg::MAX_PATTERN_DEFAULT,
   localparam int LW = $clog2(MAX_PATTERN + 1)
) (
   input  wire                     clock,
   input  wire                     reset,
   pcs_req_if.sink                 req,
   pcs_rsp_if.source               rsp,
   input  wire [LW-1:0]            len,        // effective pattern length
   input  wire                     hit,        // window front matches pattern
   input  wire [7:0]               front_byte, // oldest pending byte
   output pcs_pkg::cell_ctrl_type  ctrl,
   output logic [LW-1:0]           count
);
   import pcs_pkg::*;

   pcs_state_type state_ff, state_in;
   logic [LW-1:0] count_ff, count_in;
   logic [LW-1:0] rem_ff, rem_in, rem_next;
   logic          nl_ff, nl_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          accept;
   logic          can_out;
   logic          want;
   logic          star;
   logic          last;
   logic          scan_done;
   logic          flush_done;
   logic          fire;
   logic [LW-1:0] count_after;

   assign req.ready   = (state_ff == ST_IDLE);
   assign accept      = req.valid && req.ready;
   assign can_out     = !rsp_valid_ff || rsp.ready;
   assign count_after = count_ff - LW'(1);

   // Output decode: what the current cycle wants to emit.
   always_comb begin
      want       = 1'b0;
      star       = 1'b0;
      last       = 1'b0;
      scan_done  = 1'b0;
      flush_done = 1'b0;
      rem_next   = rem_ff;
      case (state_ff)
         ST_SCAN: begin
            if (rem_ff != '0) begin
               want     = 1'b1;
               star     = 1'b1;
               rem_next = rem_ff - LW'(1);
            end else if (count_ff >= len) begin
               want = 1'b1;
               if (hit) begin
                  star     = 1'b1;
                  rem_next = len - LW'(1);
               end
            end else begin
               scan_done = 1'b1;
            end
            // last when no stars remain, no further test and no flush follow
            last = (rem_next == '0) && (count_after < len) &&
                   !(nl_ff && (count_after != '0));
         end
         ST_FLUSH: begin
            if (count_ff != '0) begin
               want = 1'b1;
               last = (count_after == '0);
            end else begin
               flush_done = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign fire = want && can_out;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = req.stream_end ? ST_FLUSH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (fire && last) begin
               state_in = ST_IDLE;
            end else if (scan_done) begin
               state_in = nl_ff ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if ((fire && last) || flush_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (accept && !req.stream_end) begin
         count_in = count_ff + LW'(1);
      end else if (fire) begin
         count_in = count_after;
      end
      rem_in = fire ? rem_next : rem_ff;
      nl_in  = nl_ff;
      if (accept) begin
         nl_in = !req.stream_end && (req.in_byte == NEWLINE_CHAR);
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = star ? STAR_CHAR : front_byte;
         rsp_last_in  = last;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rem_ff       <= '0;
         nl_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rem_ff       <= rem_in;
         nl_ff        <= nl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign ctrl.shift       = fire;
   assign ctrl.append      = accept && !req.stream_end;
   assign ctrl.append_byte = req.in_byte;
   assign count            = count_ff;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_byte    = rsp_byte_ff;
   assign rsp.last_of_run = rsp_last_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LW'(MAX_PATTERN))
      else $error("window count beyond capacity");

   a_idle_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (count_ff < LW'(MAX_PATTERN)) && (rem_ff == '0))
      else $error("idle with full window or pending stars");

   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      (fire && (state_ff == ST_FLUSH)) |-> (last == (count_ff == LW'(1))))
      else $error("flush end marker misplaced");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (fire && last) |=> (state_ff == ST_IDLE))
      else $error("item still active after its final result");
`endif

endmodule

`default_nettype wire

[design/pattern_censor_stream.sv]
// Streaming pattern censor, top level.
// Input items arrive on req (in_byte, stream_end), results leave on rsp
// (out_byte, last_of_run); both are valid/ready channels, a transfer on an
// edge where valid and ready are both high. The csr port writes the pattern
// length and the two pattern words (indexes 0, 1, 2); the user must do so
// only while the block is idle, which the block itself does not enforce.
// Each leftmost, non-overlapping occurrence of the pattern within a line
// is replaced by asterisks; a newline or a stream_end item flushes the
// window. last_of_run marks the final result of each input item. The
// window is a chain of MAX_PATTERN byte cells stepped by one sequencer;
// every result takes one sequencer step. An input item is transferred,
// then scanned; a newline item whose scan leaves bytes in the window then
// flushes them. The first result is registered by the sequencer step that
// follows the input transfer (by the first flush step when a newline item
// has no full window to test). When rsp stalls, the result register holds
// and the sequencer waits; no input is taken until the current item is
// finished. Reset (synchronous) empties the window, sets length 1 and
// clears the pattern words.
// Depends on pcs_pkg, pcs_req_if, pcs_rsp_if, pcs_cell and pcs_seq.
`default_nettype none

module pattern_censor_stream #(
   parameter int MAX_PATTERN = pcs_pkg::MAX_PATTERN_DEFAULT
) (
   input  wire                              clock,
   input  wire                              reset,
   pcs_req_if.sink                          req,
   pcs_rsp_if.source                        rsp,
   input  wire                              csr_we,
   input  wire [pcs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire [pcs_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import pcs_pkg::*;

   localparam int LW = $clog2(MAX_PATTERN + 1);
   localparam logic [6:0] MAX7 = 7'(MAX_PATTERN);

   logic [LW-1:0]          len_ff, len_in;
   logic [CSR_DATA_W-1:0]  pat_lo_ff, pat_lo_in;
   logic [CSR_DATA_W-1:0]  pat_hi_ff, pat_hi_in;
   logic [6:0]             len_wr;

   cell_ctrl_type          ctrl;
   logic [LW-1:0]          count;
   logic [7:0]             win   [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] ok;
   logic                   hit;

   // Pattern length saturates to 1..MAX_PATTERN at write time.
   assign len_wr = {2'b00, csr_wdata[LEN_FIELD_W-1:0]};

   always_comb begin
      len_in    = len_ff;
      pat_lo_in = pat_lo_ff;
      pat_hi_in = pat_hi_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PATTERN_LEN: begin
               if (len_wr == 7'd0) begin
                  len_in = LW'(1);
               end else if (len_wr > MAX7) begin
                  len_in = LW'(MAX_PATTERN);
               end else begin
                  len_in = LW'(len_wr);
               end
            end
            CSR_PATTERN_LOW:  pat_lo_in = csr_wdata;
            CSR_PATTERN_HIGH: pat_hi_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= LW'(1);
         pat_lo_ff <= '0;
         pat_hi_ff <= '0;
      end else begin
         len_ff    <= len_in;
         pat_lo_ff <= pat_lo_in;
         pat_hi_ff <= pat_hi_in;
      end
   end

   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
      logic [7:0] pat_byte;
      logic [7:0] next_byte;

      if (i < 8) begin : g_lo
         assign pat_byte = pat_lo_ff[8*i +: 8];
      end else if (i < PATTERN_BYTES) begin : g_hi
         assign pat_byte = pat_hi_ff[8*(i-8) +: 8];
      end else begin : g_zero
         assign pat_byte = 8'h00;
      end

      if (i < MAX_PATTERN - 1) begin : g_link
         assign next_byte = win[i+1];
      end else begin : g_end
         assign next_byte = 8'h00;
      end

      pcs_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .sel       (count == LW'(i)),
         .care      (LW'(i) < len_ff),
         .pat_byte  (pat_byte),
         .next_byte (next_byte),
         .win_byte  (win[i]),
         .ok        (ok[i])
      );
   end

   assign hit = &ok;

   pcs_seq #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .len        (len_ff),
      .hit        (hit),
      .front_byte (win[0]),
      .ctrl       (ctrl),
      .count      (count)
   );

endmodule

`default_nettype wire
